// ===== rtl/wfa_pkg.sv =====
package wfa_pkg;

  // Default sizing of the block table
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed field widths of the channels
  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int FRAG_FIELD_W = 16;
  localparam int SUM_W        = 20;
  localparam int BC_W         = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_BLOCK_COUNT = 1'b0;  // word index of block_count

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } wfa_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic commit;
  } wfa_cmd_t;

endpackage

// ===== rtl/wfa_if.sv =====
interface wfa_in_if;
  import wfa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [IDX_FIELD_W-1:0]  block_index;
  logic [SIZE_FIELD_W-1:0] size_value;

  modport source(output valid, command, block_index, size_value, input ready);
  modport sink(input valid, command, block_index, size_value, output ready);
endinterface

interface wfa_out_if;
  import wfa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [IDX_FIELD_W-1:0]  chosen_block;
  logic [FRAG_FIELD_W-1:0] fragment;
  logic [SUM_W-1:0]        total_fragment;

  modport source(output valid, granted, chosen_block, fragment, total_fragment,
                 input ready);
  modport sink(input valid, granted, chosen_block, fragment, total_fragment,
               output ready);
endinterface

// ===== rtl/wfa_ram.sv =====
module wfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wfa_ctrl.sv =====
module wfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              scan_done,
  output wfa_pkg::wfa_cmd_t cmd
);
  import wfa_pkg::*;

  wfa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_command == CMD_REQUEST)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && (in_command == CMD_LOAD);
        cmd.start = in_valid && (in_command == CMD_REQUEST);
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The result register is full from commit until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/wfa_datapath.sv =====
module wfa_datapath #(
  parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfa_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wfa_pkg::wfa_cmd_t                cmd,
  input  logic [wfa_pkg::IDX_FIELD_W-1:0]  in_block_index,
  input  logic [wfa_pkg::SIZE_FIELD_W-1:0] in_size_value,
  input  logic [wfa_pkg::BC_W-1:0]         block_count,
  output logic                             scan_done,
  output logic                             out_granted,
  output logic [wfa_pkg::IDX_FIELD_W-1:0]  out_chosen_block,
  output logic [wfa_pkg::FRAG_FIELD_W-1:0] out_fragment,
  output logic [wfa_pkg::SUM_W-1:0]        out_total_fragment
);
  import wfa_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ADD_W = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;

  logic [SIZE_BITS-1:0]  req_size_r;
  logic [CNT_W-1:0]      lim_r;
  logic [CNT_W-1:0]      scan_idx_r;
  logic                  rd_pend_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [SIZE_BITS-1:0]  best_size_r;
  logic [MAX_BLOCKS-1:0] marks_r;
  logic [SUM_W-1:0]      sum_r;

  logic                  load_ok;
  logic [IDX_W-1:0]      load_idx;
  logic [SIZE_BITS-1:0]  in_size;
  logic [CNT_W-1:0]      lim;
  logic                  issue;
  logic [SIZE_BITS-1:0]  rd_size;
  logic                  candidate;
  logic [SIZE_BITS-1:0]  frag;
  logic [ADD_W-1:0]      sum_ext;
  logic [SUM_W-1:0]      sum_nxt;

  // Load decode; indexes beyond the table are dropped
  assign load_ok  = cmd.load && (32'(in_block_index) < 32'(MAX_BLOCKS));
  assign load_idx = IDX_W'(in_block_index);
  assign in_size  = SIZE_BITS'(in_size_value);

  // Scan limit, clipped to the table depth
  assign lim = (32'(block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(block_count);

  assign issue     = cmd.scan && (scan_idx_r != lim_r);
  assign scan_done = (scan_idx_r == lim_r) && !rd_pend_r;

  // Block size table
  wfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_idx),
    .wdata (in_size),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (rd_size)
  );

  // Compare stage: a free block that fits and is strictly larger replaces the best
  assign candidate = rd_pend_r && !marks_r[rd_idx_r] && (rd_size >= req_size_r) &&
                     (!found_r || (rd_size > best_size_r));

  // Fragment and saturating running total
  assign frag    = best_size_r - req_size_r;
  assign sum_ext = ADD_W'(sum_r) + ADD_W'(frag);
  assign sum_nxt = (sum_ext > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_ext);

  // Scan control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      lim_r      <= '0;
      rd_pend_r  <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.start) begin
      scan_idx_r <= '0;
      lim_r      <= lim;
      rd_pend_r  <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (candidate) begin
        found_r <= 1'b1;
      end
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_size_r <= in_size;
    end
    if (issue) begin
      rd_idx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (candidate) begin
      best_idx_r  <= rd_idx_r;
      best_size_r <= rd_size;
    end
  end

  // Allocation marks and fragment total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      sum_r   <= '0;
    end else begin
      if (load_ok) begin
        marks_r[load_idx] <= 1'b0;
      end
      if (cmd.commit && found_r) begin
        marks_r[best_idx_r] <= 1'b1;
        sum_r               <= sum_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted        <= found_r;
      out_chosen_block   <= found_r ? IDX_FIELD_W'(best_idx_r) : '0;
      out_fragment       <= found_r ? FRAG_FIELD_W'(frag) : '0;
      out_total_fragment <= found_r ? sum_nxt : sum_r;
    end
  end

endmodule

// ===== rtl/worst_fit_block_allocator_top.sv =====
// Channel   Direction  Contents
// in_ch     sink       command, block_index, size_value
// out_ch    source     granted, chosen_block, fragment, total_fragment
// cfg_*     APB slave  block_count at byte address 0
//
// A load transaction gives no result.
// A request keeps the input closed until its commit. It makes N table reads, where
// N = min(block_count, MAX_BLOCKS): one table read per cycle through the single
// read port of the size memory, then a final compare, a scan-end step and a commit.
// With N zero there are no reads and nothing to compare.
// Reset is synchronous and active low; it clears the allocation marks and the
// fragment total, while the size table keeps whatever it held.
// A result waiting in the output register does not stop loads; a request holds
// at commit until that result has been taken.
module worst_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfa_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wfa_in_if.sink                         in_ch,
  wfa_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wfa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wfa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wfa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import wfa_pkg::*;

  logic [BC_W-1:0] block_count_r;
  logic            cfg_sel_bc;
  wfa_cmd_t        cmd;
  logic            scan_done;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_sel_bc = (cfg_paddr[2] == REG_BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_bc) begin
      block_count_r <= cfg_pwdata[BC_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_bc ? CFG_DATA_W'(block_count_r) : '0;

  // Sequencer
  wfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .scan_done  (scan_done),
    .cmd        (cmd)
  );

  // Table, scan and result datapath
  wfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_block_index     (in_ch.block_index),
    .in_size_value      (in_ch.size_value),
    .block_count        (block_count_r),
    .scan_done          (scan_done),
    .out_granted        (out_ch.granted),
    .out_chosen_block   (out_ch.chosen_block),
    .out_fragment       (out_ch.fragment),
    .out_total_fragment (out_ch.total_fragment)
  );

endmodule

// ===== rtl/wfa_checker.sv =====
module wfa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_granted,
  input logic [wfa_pkg::IDX_FIELD_W-1:0]  out_chosen_block,
  input logic [wfa_pkg::FRAG_FIELD_W-1:0] out_fragment,
  input logic [wfa_pkg::SUM_W-1:0]        out_total_fragment
);
  import wfa_pkg::*;

  // A stalled result transaction keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) &&
      $stable(out_chosen_block) && $stable(out_fragment) &&
      $stable(out_total_fragment))
    else $error("result changed while stalled");

  // A refused request reports no block and no fragment
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> (out_chosen_block == '0) && (out_fragment == '0))
    else $error("refused request carries a block or fragment");

  // The running total always covers the fragment just added
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_fragment >= SUM_W'(out_fragment)))
    else $error("total fragment below the fragment");

  // No result is offered straight out of reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind worst_fit_block_allocator_top wfa_checker u_wfa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_granted        (out_ch.granted),
  .out_chosen_block   (out_ch.chosen_block),
  .out_fragment       (out_ch.fragment),
  .out_total_fragment (out_ch.total_fragment)
);
